// ===== rtl/fbcd_pkg.sv =====
// fbcd_pkg: shared types and constants for the fsk bit classifier and byte deframer
// symbol codes, result status codes and the per-depth window bounds
// no dependencies
package fbcd_pkg;

	localparam int unsigned FIELD_BITS = 16;

	typedef enum logic [1:0] {
		SYM_ZERO = 2'd0,
		SYM_ONE  = 2'd1,
		SYM_BAD  = 2'd2
	} sym_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_PARITY  = 2'd1,
		ST_STOP    = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	// window bounds, lower inclusive for a one, upper exclusive
	function automatic logic [4:0] win_low(input logic [1:0] depth);
		logic [4:0] v;
		unique case (depth)
			2'd0: v = 5'd3;
			2'd1: v = 5'd5;
			2'd2: v = 5'd9;
			2'd3: v = 5'd18;
			default: v = 5'd3;
		endcase
		return v;
	endfunction

	function automatic logic [4:0] win_high(input logic [1:0] depth);
		logic [4:0] v;
		unique case (depth)
			2'd0: v = 5'd5;
			2'd1: v = 5'd7;
			2'd2: v = 5'd12;
			2'd3: v = 5'd21;
			default: v = 5'd5;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/fbcd_classify.sv =====
// fbcd_classify: turns a pair of timer periods into a zero, one or invalid symbol
// absolute difference compared against the depth-selected window
// depends on fbcd_pkg
module fbcd_classify #(
	parameter int unsigned PERIOD_BITS = 16
) (
	input  logic [fbcd_pkg::FIELD_BITS-1:0] half_period,
	input  logic [fbcd_pkg::FIELD_BITS-1:0] full_period,
	input  logic [1:0]                      depth,
	output fbcd_pkg::sym_t                  sym
);

	localparam int unsigned EFF_BITS = (PERIOD_BITS < fbcd_pkg::FIELD_BITS) ?
		PERIOD_BITS : fbcd_pkg::FIELD_BITS;
	localparam logic [fbcd_pkg::FIELD_BITS:0] MASK_WIDE =
		(({{fbcd_pkg::FIELD_BITS{1'b0}}, 1'b1}) << EFF_BITS) - 1'b1;
	localparam logic [fbcd_pkg::FIELD_BITS-1:0] MASK = MASK_WIDE[fbcd_pkg::FIELD_BITS-1:0];

	logic [fbcd_pkg::FIELD_BITS-1:0] a;
	logic [fbcd_pkg::FIELD_BITS-1:0] b;
	logic [fbcd_pkg::FIELD_BITS-1:0] diff;
	logic [fbcd_pkg::FIELD_BITS-1:0] lo;
	logic [fbcd_pkg::FIELD_BITS-1:0] hi;

	assign a    = half_period & MASK;
	assign b    = full_period & MASK;
	assign diff = (a >= b) ? (a - b) : (b - a);
	assign lo   = {{(fbcd_pkg::FIELD_BITS-5){1'b0}}, fbcd_pkg::win_low(depth)};
	assign hi   = {{(fbcd_pkg::FIELD_BITS-5){1'b0}}, fbcd_pkg::win_high(depth)};

	always_comb begin
		priority if (diff < lo) begin
			sym = fbcd_pkg::SYM_ZERO;
		end else if (diff < hi) begin
			sym = fbcd_pkg::SYM_ONE;
		end else begin
			sym = fbcd_pkg::SYM_BAD;
		end
	end

endmodule

// ===== rtl/fsk_bit_classify_byte_deframe.sv =====
// fsk_bit_classify_byte_deframe: top level of the fsk bit classifier and byte deframer
// input register, classifier, frame state and result register
// depends on fbcd_pkg and fbcd_classify
//
// Each transfer on the input channel carries a half-bit and a full-bit timer period. Their
// absolute difference, taken over the low PERIOD_BITS bits, is classified against the window
// chosen by fsk_depth into a 0, a 1 or an invalid symbol. Symbols are framed as a start 0,
// eight data bits LSB first, odd parity and a stop 1. A finished frame gives one result with
// the byte and status ok; a parity, stop or invalid-symbol fault inside a frame gives one
// result with that status and a zero byte, and restarts the framing. Every other item gives
// no result. One item is taken per clock: the item is held in the input register and its
// result, if any, is then registered in the result register; the rate drops only while an
// unread result holds the result register.
module fsk_bit_classify_byte_deframe #(
	parameter int unsigned PERIOD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] half_period,
	input  logic [15:0] full_period,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic [1:0]  status
);

	localparam logic [3:0] POS_IDLE   = 4'd0;
	localparam logic [3:0] POS_PARITY = 4'd9;
	localparam logic [3:0] POS_STOP   = 4'd10;

	logic [1:0]  depth_q;
	logic        valid_s1;
	logic [15:0] half_s1;
	logic [15:0] full_s1;
	logic        adv_s1;

	logic [3:0]  pos_q;
	logic [7:0]  shift_q;
	logic        parity_q;
	logic [3:0]  pos_n;
	logic [7:0]  shift_n;
	logic        parity_n;
	logic        emit;
	logic [7:0]  emit_byte;
	fbcd_pkg::status_t emit_status;
	fbcd_pkg::sym_t    sym;
	logic        bit_val;
	logic [2:0]  bit_idx;

	logic        out_valid_q;
	logic [7:0]  data_byte_q;
	logic [1:0]  status_q;

	fbcd_classify #(
		.PERIOD_BITS(PERIOD_BITS)
	) u_classify (
		.half_period(half_s1),
		.full_period(full_s1),
		.depth      (depth_q),
		.sym        (sym)
	);

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	assign bit_val = (sym == fbcd_pkg::SYM_ONE);
	assign bit_idx = 3'(pos_q - 4'd1);

	always_comb begin
		pos_n       = pos_q;
		shift_n     = shift_q;
		parity_n    = parity_q;
		emit        = 1'b0;
		emit_byte   = 8'd0;
		emit_status = fbcd_pkg::ST_OK;
		priority if (pos_q == POS_IDLE) begin
			if (sym == fbcd_pkg::SYM_ZERO) begin
				pos_n = 4'd1;
			end
		end else if (pos_q > POS_STOP) begin
			pos_n    = POS_IDLE;
			shift_n  = 8'd0;
			parity_n = 1'b1;
		end else if (sym == fbcd_pkg::SYM_BAD) begin
			emit        = 1'b1;
			emit_status = fbcd_pkg::ST_INVALID;
		end else if (pos_q < POS_PARITY) begin
			shift_n[bit_idx] = bit_val;
			parity_n         = parity_q ^ bit_val;
			pos_n            = pos_q + 4'd1;
		end else if (pos_q == POS_PARITY) begin
			if (bit_val != parity_q) begin
				emit        = 1'b1;
				emit_status = fbcd_pkg::ST_PARITY;
			end else begin
				pos_n = POS_STOP;
			end
		end else begin
			emit = 1'b1;
			if (bit_val) begin
				emit_byte   = shift_q;
				emit_status = fbcd_pkg::ST_OK;
			end else begin
				emit_status = fbcd_pkg::ST_STOP;
			end
		end
		// any result ends the frame
		if (emit) begin
			pos_n    = POS_IDLE;
			shift_n  = 8'd0;
			parity_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= 2'd0;
		end else if (cfg_wr_en) begin
			depth_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			half_s1 <= half_period;
			full_s1 <= full_period;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_IDLE;
			shift_q  <= 8'd0;
			parity_q <= 1'b1;
		end else if (adv_s1) begin
			pos_q    <= pos_n;
			shift_q  <= shift_n;
			parity_q <= parity_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			data_byte_q <= emit_byte;
			status_q    <= emit_status;
		end
	end

	assign out_valid = out_valid_q;
	assign data_byte = data_byte_q;
	assign status    = status_q;

endmodule
